[src/cbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour background subtractor package
// Field widths, register map, configuration bundle and shared helpers.
// ----------------------------------------------------------------------------
package cbs_pkg;

   // Default geometry of the sample model.
   localparam int SAMPLES_DEF    = 16;
   localparam int IMG_WIDTH_DEF  = 640;
   localparam int IMG_HEIGHT_DEF = 480;

   // Request and response field widths.
   localparam int COLOR_W  = 8;
   localparam int PIXEL_W  = 3 * COLOR_W;
   localparam int POS_X_W  = 10;
   localparam int POS_Y_W  = 9;
   localparam int SLOT_W   = 4;
   localparam int DRAW_W   = 16;
   localparam int DIR_W    = 3;
   localparam int MATCH_W  = 5;

   // Internal widths. Coordinates hold any image size up to 4096.
   localparam int COORD_W    = 13;
   localparam int THR_W      = 8;
   localparam int RATE_W     = 8;
   localparam int DIV_W      = 8;
   localparam int LIM_W      = 10;
   localparam int LIM_SQ_W   = 20;
   localparam int DIST_SUM_W = 10;
   localparam int DIST_SQ_W  = 18;
   localparam int SQ_W       = 2 * COLOR_W;

   // Remainder unit: bits retired per cycle.
   localparam int REM_STEPS = 4;

   // Register port.
   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;

   typedef enum logic [2:0] {
      REG_DIST_THR    = 3'd0,
      REG_REQ_MATCHES = 3'd1,
      REG_UPDATE_RATE = 3'd2,
      REG_USE_L1      = 3'd3,
      REG_CHK_EN      = 3'd4,
      REG_CHK_THR     = 3'd5
   } reg_index_type;

   localparam logic [THR_W-1:0]   RST_DIST_THR    = 8'd20;
   localparam logic [MATCH_W-1:0] RST_REQ_MATCHES = 5'd2;
   localparam logic [RATE_W-1:0]  RST_UPDATE_RATE = 8'd16;
   localparam logic               RST_USE_L1      = 1'b0;
   localparam logic               RST_CHK_EN      = 1'b0;
   localparam logic [THR_W-1:0]   RST_CHK_THR     = 8'd20;

   typedef struct packed {
      logic [MATCH_W-1:0]  req_matches;
      logic [RATE_W-1:0]   rate;
      logic                use_l1;
      logic                chk_en;
      logic [THR_W-1:0]    chk_thr;
      logic [LIM_W-1:0]    lim_l1;
      logic [LIM_SQ_W-1:0] lim_sq;
   } cfg_type;

   // Neighbour offsets, one bit per direction, clockwise from the top left.
   localparam logic [7:0] NBR_X_DEC = 8'b1100_0001;
   localparam logic [7:0] NBR_X_INC = 8'b0001_1100;
   localparam logic [7:0] NBR_Y_DEC = 8'b0000_0111;
   localparam logic [7:0] NBR_Y_INC = 8'b0111_0000;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

[src/cbs_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one pixel, sample load or classify request.
// ----------------------------------------------------------------------------
interface cbs_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [cbs_pkg::POS_X_W-1:0]  pos_x;
   logic [cbs_pkg::POS_Y_W-1:0]  pos_y;
   logic [cbs_pkg::COLOR_W-1:0]  red;
   logic [cbs_pkg::COLOR_W-1:0]  green;
   logic [cbs_pkg::COLOR_W-1:0]  blue;
   logic [cbs_pkg::SLOT_W-1:0]   load_slot;
   logic [cbs_pkg::DRAW_W-1:0]   draw_self_gate;
   logic [cbs_pkg::DRAW_W-1:0]   draw_self_slot;
   logic [cbs_pkg::DRAW_W-1:0]   draw_nbr_gate;
   logic [cbs_pkg::DRAW_W-1:0]   draw_nbr_slot;
   logic [cbs_pkg::DIR_W-1:0]    nbr_direction;

   modport source (
      output valid, func, pos_x, pos_y, red, green, blue, load_slot,
             draw_self_gate, draw_self_slot, draw_nbr_gate, draw_nbr_slot,
             nbr_direction,
      input  ready
   );

   modport sink (
      input  valid, func, pos_x, pos_y, red, green, blue, load_slot,
             draw_self_gate, draw_self_slot, draw_nbr_gate, draw_nbr_slot,
             nbr_direction,
      output ready
   );
endinterface

[src/cbs_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the classification of one request.
// ----------------------------------------------------------------------------
interface cbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         foreground;
   logic [cbs_pkg::MATCH_W-1:0]  match_count;

   modport source (
      output valid, foreground, match_count,
      input  ready
   );

   modport sink (
      input  valid, foreground, match_count,
      output ready
   );
endinterface

[src/cbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, per-lane write enables, registered read data.
// ----------------------------------------------------------------------------
module cbs_ram #(
   parameter int LANE_W = cbs_pkg::PIXEL_W,
   parameter int LANES  = cbs_pkg::SAMPLES_DEF,
   parameter int DEPTH  = 1024
) (
   input  logic                      clock,
   input  logic [$clog2(DEPTH)-1:0]  addr,
   input  logic                      re,
   input  logic [LANES-1:0]          we,
   input  logic [LANES*LANE_W-1:0]   wdata,
   output logic [LANES*LANE_W-1:0]   rdata
);

   logic [LANES*LANE_W-1:0] mem_ff [DEPTH];
   logic [LANES*LANE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (we[l]) begin
            mem_ff[addr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
         end
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/cbs_rem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring remainder of a draw by a small divisor, several bits per cycle.
// ----------------------------------------------------------------------------
module cbs_rem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cbs_pkg::DRAW_W-1:0]  dividend,
   input  logic [cbs_pkg::DIV_W-1:0]   divisor,
   output logic                        done,
   output logic [cbs_pkg::DIV_W-1:0]   remainder
);

   localparam int CYCLES = cbs_pkg::DRAW_W / cbs_pkg::REM_STEPS;
   localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

   logic [cbs_pkg::DRAW_W-1:0] num_ff, num_in, step_num;
   logic [cbs_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [cbs_pkg::DIV_W-1:0]  rem_ff, rem_in, step_rem;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [cbs_pkg::DIV_W:0]    part;
   logic [cbs_pkg::DRAW_W-1:0] shift;

   // Each step brings down the next dividend bit and subtracts when it fits.
   always_comb begin
      part  = {1'b0, rem_ff};
      shift = num_ff;
      for (int i = 0; i < cbs_pkg::REM_STEPS; i++) begin
         part  = {part[cbs_pkg::DIV_W-1:0], shift[cbs_pkg::DRAW_W-1]};
         shift = {shift[cbs_pkg::DRAW_W-2:0], 1'b0};
         if (part >= {1'b0, div_ff}) begin
            part = part - {1'b0, div_ff};
         end
      end
      step_rem = part[cbs_pkg::DIV_W-1:0];
      step_num = shift;
   end

   always_comb begin
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = step_num;
         rem_in  = step_rem;
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != CNT_W'(CYCLES - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = !busy_ff;
   assign remainder = rem_ff;

endmodule

[src/cbs_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample comparator
// Compares a pixel with every stored sample of its line and counts matches.
// ----------------------------------------------------------------------------
module cbs_match #(
   parameter int SAMPLES = cbs_pkg::SAMPLES_DEF
) (
   input  logic                                clock,
   input  cbs_pkg::cfg_type                    cfg,
   input  logic [cbs_pkg::PIXEL_W-1:0]         pixel,
   input  logic [SAMPLES*cbs_pkg::PIXEL_W-1:0] line,
   output logic                                foreground,
   output logic [cbs_pkg::MATCH_W-1:0]         match_count
);

   localparam int PW    = cbs_pkg::PIXEL_W;
   localparam int CW    = cbs_pkg::COLOR_W;
   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int CMP_W = (CNT_W > cbs_pkg::MATCH_W) ? CNT_W : cbs_pkg::MATCH_W;

   logic [SAMPLES-1:0] hit_in, hit_ff;
   logic [CNT_W-1:0]   pop;
   logic [CMP_W-1:0]   pop_x, req_x, good;

   for (genvar s = 0; s < SAMPLES; s++) begin : g_lane
      logic [CW-1:0]                  d_r, d_g, d_b;
      logic [cbs_pkg::SQ_W-1:0]       sq_r, sq_g, sq_b;
      logic [cbs_pkg::DIST_SUM_W-1:0] dsum;
      logic [cbs_pkg::DIST_SQ_W-1:0]  dsq;
      logic                           veto;

      assign d_r = cbs_pkg::abs_diff(pixel[2*CW +: CW], line[s*PW + 2*CW +: CW]);
      assign d_g = cbs_pkg::abs_diff(pixel[CW +: CW], line[s*PW + CW +: CW]);
      assign d_b = cbs_pkg::abs_diff(pixel[0 +: CW], line[s*PW +: CW]);

      assign sq_r = cbs_pkg::SQ_W'(d_r) * cbs_pkg::SQ_W'(d_r);
      assign sq_g = cbs_pkg::SQ_W'(d_g) * cbs_pkg::SQ_W'(d_g);
      assign sq_b = cbs_pkg::SQ_W'(d_b) * cbs_pkg::SQ_W'(d_b);

      assign dsum = cbs_pkg::DIST_SUM_W'(d_r) + cbs_pkg::DIST_SUM_W'(d_g)
                  + cbs_pkg::DIST_SUM_W'(d_b);
      assign dsq  = cbs_pkg::DIST_SQ_W'(sq_r) + cbs_pkg::DIST_SQ_W'(sq_g)
                  + cbs_pkg::DIST_SQ_W'(sq_b);

      assign veto = cfg.chk_en
                  && ((d_r > cfg.chk_thr) || (d_g > cfg.chk_thr) || (d_b > cfg.chk_thr));

      assign hit_in[s] = !veto && (cfg.use_l1
                         ? (dsum < cfg.lim_l1)
                         : (cbs_pkg::LIM_SQ_W'(dsq) < cfg.lim_sq));
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   always_comb begin
      pop = '0;
      for (int s = 0; s < SAMPLES; s++) begin
         pop = pop + CNT_W'(hit_ff[s]);
      end
   end

   // Every sample is counted, but the reported count saturates at the required count.
   assign pop_x       = CMP_W'(pop);
   assign req_x       = CMP_W'(cfg.req_matches);
   assign foreground  = (pop_x < req_x);
   assign good        = foreground ? pop_x : req_x;
   assign match_count = cbs_pkg::MATCH_W'(good);

endmodule

[src/cbs_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file and the derived distance limits.
// ----------------------------------------------------------------------------
module cbs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [cbs_pkg::PADDR_W-1:0]  paddr,
   input  logic [cbs_pkg::PDATA_W-1:0]  pwdata,
   output logic [cbs_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready,
   output cbs_pkg::cfg_type             cfg
);

   logic [cbs_pkg::THR_W-1:0]    dist_ff, dist_in;
   logic [cbs_pkg::MATCH_W-1:0]  req_ff, req_in;
   logic [cbs_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic                         l1_ff, l1_in;
   logic                         chk_en_ff, chk_en_in;
   logic [cbs_pkg::THR_W-1:0]    chk_thr_ff, chk_thr_in;
   logic [cbs_pkg::LIM_SQ_W-1:0] lim_sq_ff, lim_sq_in;
   logic [cbs_pkg::LIM_W-1:0]    lim_l1;
   logic                         wr;
   cbs_pkg::reg_index_type       idx;

   assign wr     = psel && penable && pwrite;
   assign idx    = cbs_pkg::reg_index_type'(paddr[4:2]);
   assign pready = 1'b1;

   always_comb begin
      dist_in    = dist_ff;
      req_in     = req_ff;
      rate_in    = rate_ff;
      l1_in      = l1_ff;
      chk_en_in  = chk_en_ff;
      chk_thr_in = chk_thr_ff;
      if (wr) begin
         case (idx)
            cbs_pkg::REG_DIST_THR:    dist_in    = pwdata[cbs_pkg::THR_W-1:0];
            cbs_pkg::REG_REQ_MATCHES: req_in     = pwdata[cbs_pkg::MATCH_W-1:0];
            cbs_pkg::REG_UPDATE_RATE: rate_in    = pwdata[cbs_pkg::RATE_W-1:0];
            cbs_pkg::REG_USE_L1:      l1_in      = pwdata[0];
            cbs_pkg::REG_CHK_EN:      chk_en_in  = pwdata[0];
            cbs_pkg::REG_CHK_THR:     chk_thr_in = pwdata[cbs_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         cbs_pkg::REG_DIST_THR:    prdata = cbs_pkg::PDATA_W'(dist_ff);
         cbs_pkg::REG_REQ_MATCHES: prdata = cbs_pkg::PDATA_W'(req_ff);
         cbs_pkg::REG_UPDATE_RATE: prdata = cbs_pkg::PDATA_W'(rate_ff);
         cbs_pkg::REG_USE_L1:      prdata = cbs_pkg::PDATA_W'(l1_ff);
         cbs_pkg::REG_CHK_EN:      prdata = cbs_pkg::PDATA_W'(chk_en_ff);
         cbs_pkg::REG_CHK_THR:     prdata = cbs_pkg::PDATA_W'(chk_thr_ff);
         default:                  prdata = '0;
      endcase
   end

   // The compare limit is three times the threshold; its square serves the L2 test.
   assign lim_l1    = cbs_pkg::LIM_W'(dist_ff) + cbs_pkg::LIM_W'({dist_ff, 1'b0});
   assign lim_sq_in = cbs_pkg::LIM_SQ_W'(lim_l1) * cbs_pkg::LIM_SQ_W'(lim_l1);

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff    <= cbs_pkg::RST_DIST_THR;
         req_ff     <= cbs_pkg::RST_REQ_MATCHES;
         rate_ff    <= cbs_pkg::RST_UPDATE_RATE;
         l1_ff      <= cbs_pkg::RST_USE_L1;
         chk_en_ff  <= cbs_pkg::RST_CHK_EN;
         chk_thr_ff <= cbs_pkg::RST_CHK_THR;
      end else begin
         dist_ff    <= dist_in;
         req_ff     <= req_in;
         rate_ff    <= rate_in;
         l1_ff      <= l1_in;
         chk_en_ff  <= chk_en_in;
         chk_thr_ff <= chk_thr_in;
      end
      lim_sq_ff <= lim_sq_in;
   end

   always_comb begin
      cfg.req_matches = req_ff;
      cfg.rate        = (rate_ff == '0) ? cbs_pkg::RATE_W'(1) : rate_ff;
      cfg.use_l1      = l1_ff;
      cfg.chk_en      = chk_en_ff;
      cfg.chk_thr     = chk_thr_ff;
      cfg.lim_l1      = lim_l1;
      cfg.lim_sq      = lim_sq_ff;
   end

endmodule

[src/vibe_color_background_subtractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour background subtractor
// Sample-consensus foreground detection with an RGB sample store per pixel.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_chan (valid/ready). A classify request
// (func 0) reads all samples of its pixel as one wide memory line, counts the
// matches, answers foreground or background with the match count, and for a
// background pixel may rewrite one own sample and one sample of a clamped
// 3x3 neighbour. A load request (func 1) writes one sample and answers with
// foreground 0 and count 0. Software loads the model before classifying.
// One request is in flight at a time. A classify request follows the memory
// sequence: address, read, compare, count, own write (which waits for both
// gate remainders), neighbour write, done. A load request passes through
// address, load and done. The response sits in an output register, so the
// next request is accepted while it waits; if rsp_chan stays stalled the
// second request holds in its last state until the register frees. Reset
// clears the control state and the registers to their defaults; the sample
// memory is not cleared. The user must write the registers over the APB port
// only while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module vibe_color_background_subtractor #(
   parameter int SAMPLES    = cbs_pkg::SAMPLES_DEF,
   parameter int IMG_WIDTH  = cbs_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = cbs_pkg::IMG_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   cbs_req_if.sink                      req_chan,
   cbs_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [cbs_pkg::PADDR_W-1:0]  paddr,
   input  logic [cbs_pkg::PDATA_W-1:0]  pwdata,
   output logic [cbs_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PW     = cbs_pkg::PIXEL_W;
   localparam int CRW    = cbs_pkg::COORD_W;
   localparam int DW     = cbs_pkg::DIV_W;
   localparam int DRW    = cbs_pkg::DRAW_W;

   // Reciprocal of the sample count, exact for every draw of DRW bits.
   localparam int          SLOT_SH  = DRW + $clog2(SAMPLES);
   localparam int          PROD_W   = 2 * DRW + 1;
   localparam logic [DRW:0] SLOT_MUL =
      (DRW + 1)'(((64'd1 << SLOT_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_ADDR  = 9'b0_0000_0010,
      S_READ  = 9'b0_0000_0100,
      S_CMP   = 9'b0_0000_1000,
      S_COUNT = 9'b0_0001_0000,
      S_SELF  = 9'b0_0010_0000,
      S_NBR   = 9'b0_0100_0000,
      S_DONE  = 9'b0_1000_0000,
      S_LOAD  = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   cbs_pkg::cfg_type cfg;

   // Request held for the whole item.
   logic                          func_ff, func_in;
   logic [CRW-1:0]                x_ff, x_in, y_ff, y_in;
   logic [PW-1:0]                 pixel_ff, pixel_in;
   logic [cbs_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [cbs_pkg::DIR_W-1:0]     dir_ff, dir_in;
   logic [CRW-1:0]                x_req, y_req;
   logic [DRW-1:0]                ss_draw_ff, ss_draw_in, ns_draw_ff, ns_draw_in;
   logic [DRW-1:0]                ss_quo_ff, ns_quo_ff;
   logic [PROD_W-1:0]             ss_prod, ns_prod;

   logic [ADDR_W-1:0]             addr_ff, addr_in, nbr_addr_ff, nbr_addr_in;
   logic [CRW-1:0]                nx, ny;

   logic                          fg_ff, fg_in;
   logic [cbs_pkg::MATCH_W-1:0]   cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_fg_ff, rsp_fg_in;
   logic [cbs_pkg::MATCH_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic                          accept, out_free;
   logic                          match_fg;
   logic [cbs_pkg::MATCH_W-1:0]   match_cnt;

   logic                          rem_done_sg, rem_done_ng;
   logic [DW-1:0]                 rem_sg, rem_ss, rem_ng, rem_ns;
   logic                          rem_all_done, load_ok;

   logic [ADDR_W-1:0]             ram_addr;
   logic                          ram_re;
   logic [SAMPLES-1:0]            ram_we;
   logic [SAMPLES*PW-1:0]         ram_wdata, ram_rdata;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !reset;

   // Positions beyond the image saturate to the last column and row.
   always_comb begin
      x_req = CRW'(req_chan.pos_x);
      y_req = CRW'(req_chan.pos_y);
      if (x_req >= CRW'(IMG_WIDTH)) begin
         x_req = CRW'(IMG_WIDTH - 1);
      end
      if (y_req >= CRW'(IMG_HEIGHT)) begin
         y_req = CRW'(IMG_HEIGHT - 1);
      end
   end

   always_comb begin
      func_in    = func_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      pixel_in   = pixel_ff;
      slot_in    = slot_ff;
      dir_in     = dir_ff;
      ss_draw_in = ss_draw_ff;
      ns_draw_in = ns_draw_ff;
      if (accept) begin
         func_in    = req_chan.func;
         x_in       = x_req;
         y_in       = y_req;
         pixel_in   = {req_chan.red, req_chan.green, req_chan.blue};
         slot_in    = req_chan.load_slot;
         dir_in     = req_chan.nbr_direction;
         ss_draw_in = req_chan.draw_self_slot;
         ns_draw_in = req_chan.draw_nbr_slot;
      end
   end

   // The slot draws are reduced by the sample count through a multiplication
   // by its reciprocal; the quotient is registered before the subtraction.
   assign ss_prod = PROD_W'(ss_draw_ff) * PROD_W'(SLOT_MUL);
   assign ns_prod = PROD_W'(ns_draw_ff) * PROD_W'(SLOT_MUL);
   assign rem_ss  = DW'(ss_draw_ff - ss_quo_ff * DRW'(SAMPLES));
   assign rem_ns  = DW'(ns_draw_ff - ns_quo_ff * DRW'(SAMPLES));

   // Neighbour coordinates, clamped into the image.
   always_comb begin
      nx = x_ff;
      ny = y_ff;
      if (cbs_pkg::NBR_X_DEC[dir_ff] && (x_ff != '0)) begin
         nx = x_ff - 1'b1;
      end else if (cbs_pkg::NBR_X_INC[dir_ff] && (x_ff != CRW'(IMG_WIDTH - 1))) begin
         nx = x_ff + 1'b1;
      end
      if (cbs_pkg::NBR_Y_DEC[dir_ff] && (y_ff != '0)) begin
         ny = y_ff - 1'b1;
      end else if (cbs_pkg::NBR_Y_INC[dir_ff] && (y_ff != CRW'(IMG_HEIGHT - 1))) begin
         ny = y_ff + 1'b1;
      end
   end

   assign addr_in     = ADDR_W'(32'(y_ff) * 32'(IMG_WIDTH) + 32'(x_ff));
   assign nbr_addr_in = ADDR_W'(32'(ny) * 32'(IMG_WIDTH) + 32'(nx));

   cbs_rem u_rem_self_gate (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_chan.draw_self_gate),
      .divisor   (cfg.rate),
      .done      (rem_done_sg),
      .remainder (rem_sg)
   );

   cbs_rem u_rem_nbr_gate (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_chan.draw_nbr_gate),
      .divisor   (cfg.rate),
      .done      (rem_done_ng),
      .remainder (rem_ng)
   );

   assign rem_all_done = rem_done_sg && rem_done_ng;
   assign load_ok      = (DW'(slot_ff) < DW'(SAMPLES));

   cbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cbs_ram #(
      .LANE_W (PW),
      .LANES  (SAMPLES),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .re    (ram_re),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   cbs_match #(
      .SAMPLES (SAMPLES)
   ) u_match (
      .clock       (clock),
      .cfg         (cfg),
      .pixel       (pixel_ff),
      .line        (ram_rdata),
      .foreground  (match_fg),
      .match_count (match_cnt)
   );

   // Every write carries the request colour; the lane enables pick the slot.
   assign ram_wdata = {SAMPLES{pixel_ff}};
   assign ram_addr  = (state_ff == S_NBR) ? nbr_addr_ff : addr_ff;

   always_comb begin
      ram_re = 1'b0;
      ram_we = '0;
      case (state_ff)
         S_READ: begin
            ram_re = 1'b1;
         end
         S_LOAD: begin
            if (load_ok) begin
               ram_we = SAMPLES'(1) << slot_ff;
            end
         end
         S_SELF: begin
            if (rem_all_done && !fg_ff && (rem_sg == '0)) begin
               ram_we = SAMPLES'(1) << rem_ss;
            end
         end
         S_NBR: begin
            if (!fg_ff && (rem_ng == '0)) begin
               ram_we = SAMPLES'(1) << rem_ns;
            end
         end
         default: ;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      fg_in        = fg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_fg_in    = rsp_fg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            state_in = func_ff ? S_LOAD : S_READ;
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_COUNT;
         end
         S_COUNT: begin
            fg_in    = match_fg;
            cnt_in   = match_cnt;
            state_in = S_SELF;
         end
         S_SELF: begin
            if (rem_all_done) begin
               state_in = S_NBR;
            end
         end
         S_NBR: begin
            state_in = S_DONE;
         end
         S_LOAD: begin
            fg_in    = 1'b0;
            cnt_in   = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fg_in    = fg_ff;
               rsp_cnt_in   = cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      pixel_ff    <= pixel_in;
      slot_ff     <= slot_in;
      dir_ff      <= dir_in;
      ss_draw_ff  <= ss_draw_in;
      ns_draw_ff  <= ns_draw_in;
      ss_quo_ff   <= DRW'(ss_prod >> SLOT_SH);
      ns_quo_ff   <= DRW'(ns_prod >> SLOT_SH);
      addr_ff     <= addr_in;
      nbr_addr_ff <= nbr_addr_in;
      fg_ff       <= fg_in;
      cnt_ff      <= cnt_in;
      rsp_fg_ff   <= rsp_fg_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.foreground  = rsp_fg_ff;
   assign rsp_chan.match_count = rsp_cnt_ff;

endmodule
